// ----- design/bpc_pkg.sv -----
`default_nettype none

package bpc_pkg;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int STAMP_BITS    = 32;

    localparam logic [CFG_ADDR_BITS-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SHORT_PRESS   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LONG_PRESS    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DOUBLE_WINDOW = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PRESSED_LEVEL = 3'd4;

    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [CFG_DATA_BITS-1:0] SHORT_PRESS_RST   = 16'd300;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [CFG_DATA_BITS-1:0] DOUBLE_WINDOW_RST = 16'd300;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SINGLE = 2'd1;
    localparam logic [1:0] EV_DOUBLE = 2'd2;
    localparam logic [1:0] EV_LONG   = 2'd3;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2,
        PH_DCHECK   = 2'd3
    } phase_t;

    typedef struct packed {
        logic                  func;
        logic                  pin_level;
        logic [STAMP_BITS-1:0] now_ms;
    } bpc_in_t;

    typedef struct packed {
        logic [1:0] press_event;
        logic       analysis_active;
    } bpc_out_t;

endpackage

`default_nettype wire

// ----- design/button_press_classifier.sv -----
// Button press classifier: single, double and long press detection.
// The result is registered when the input is transferred; the result register holds it.
// Throughput: one item per cycle; the input is taken whenever the result register
// is empty or its result is transferred in the same cycle.
// Reset (aresetn low, synchronous): phase idle, time stamps and count cleared,
// registers at their defaults, no result pending.
`default_nettype none

module button_press_classifier #(
    parameter int TIME_BITS = 32
) (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  bpc_pkg::bpc_in_t                        s_data,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output bpc_pkg::bpc_out_t                       m_data,
    input  wire                                     cfg_we,
    input  wire  [bpc_pkg::CFG_ADDR_BITS-1:0]       cfg_addr,
    input  wire  [bpc_pkg::CFG_DATA_BITS-1:0]       cfg_wdata
);
    import bpc_pkg::*;

    typedef logic [TIME_BITS-1:0] stamp_t;

    logic [CFG_DATA_BITS-1:0] debounce_reg;
    logic [CFG_DATA_BITS-1:0] short_press_reg;
    logic [CFG_DATA_BITS-1:0] long_press_reg;
    logic [CFG_DATA_BITS-1:0] double_window_reg;
    logic                     pressed_level_reg;

    phase_t     phase_reg, phase_next;
    stamp_t     press_time_reg, press_time_next;
    stamp_t     release_time_reg, release_time_next;
    stamp_t     last_edge_reg, last_edge_next;
    logic [1:0] count_reg, count_next;
    logic       ticking_reg, ticking_next;
    logic       m_valid_reg;
    bpc_out_t   m_data_reg;
    logic [1:0] event_next;

    logic [TIME_BITS+STAMP_BITS-1:0]    now_wide;
    logic [TIME_BITS+CFG_DATA_BITS-1:0] debounce_wide, short_wide, long_wide, window_wide;
    stamp_t now;
    stamp_t since_edge, since_press, hold_time, since_release;
    logic   take;
    logic   is_tick, edge_ok, is_press, long_hit, short_hit, window_over;

    assign now_wide      = {{TIME_BITS{1'b0}}, s_data.now_ms};
    assign now           = now_wide[TIME_BITS-1:0];
    assign debounce_wide = {{TIME_BITS{1'b0}}, debounce_reg};
    assign short_wide    = {{TIME_BITS{1'b0}}, short_press_reg};
    assign long_wide     = {{TIME_BITS{1'b0}}, long_press_reg};
    assign window_wide   = {{TIME_BITS{1'b0}}, double_window_reg};

    assign since_edge    = now - last_edge_reg;
    assign since_press   = now - press_time_reg;
    assign hold_time     = release_time_reg - press_time_reg;
    assign since_release = now - release_time_reg;

    assign s_ready     = !m_valid_reg || m_ready;
    assign take        = s_valid && s_ready;
    assign is_tick     = (s_data.func == FUNC_TICK) && ticking_reg;
    assign edge_ok     = (s_data.func == FUNC_EDGE)
                         && (since_edge > debounce_wide[TIME_BITS-1:0]);
    assign is_press    = (s_data.pin_level == pressed_level_reg);
    assign long_hit    = since_press > long_wide[TIME_BITS-1:0];
    assign short_hit   = hold_time <= short_wide[TIME_BITS-1:0];
    assign window_over = since_release > window_wide[TIME_BITS-1:0];

    always_comb begin
        phase_next        = phase_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        last_edge_next    = last_edge_reg;
        count_next        = count_reg;
        ticking_next      = ticking_reg;
        if (edge_ok) begin
            last_edge_next = now;
            if (is_press) begin
                press_time_next = now;
                phase_next      = PH_PRESSED;
                ticking_next    = 1'b1;
            end else begin
                release_time_next = now;
                phase_next        = PH_RELEASED;
            end
        end else if (is_tick) begin
            case (phase_reg)
                PH_RELEASED: begin
                    if (!long_hit && short_hit) begin
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + 2'd1;
                        end
                        phase_next = PH_DCHECK;
                    end else begin
                        phase_next   = PH_IDLE;
                        count_next   = 2'd0;
                        ticking_next = 1'b0;
                    end
                end
                PH_DCHECK: begin
                    if (window_over) begin
                        phase_next   = PH_IDLE;
                        count_next   = 2'd0;
                        ticking_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        event_next = EV_NONE;
        if (is_tick) begin
            case (phase_reg)
                PH_RELEASED: begin
                    if (long_hit) begin
                        event_next = EV_LONG;
                    end else if (!short_hit) begin
                        event_next = EV_SINGLE;
                    end
                end
                PH_DCHECK: begin
                    if (window_over) begin
                        if (count_reg == 2'd1) begin
                            event_next = EV_SINGLE;
                        end else if (count_reg == 2'd2) begin
                            event_next = EV_DOUBLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= DEBOUNCE_RST;
            short_press_reg   <= SHORT_PRESS_RST;
            long_press_reg    <= LONG_PRESS_RST;
            double_window_reg <= DOUBLE_WINDOW_RST;
            pressed_level_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE:      debounce_reg      <= cfg_wdata;
                REG_SHORT_PRESS:   short_press_reg   <= cfg_wdata;
                REG_LONG_PRESS:    long_press_reg    <= cfg_wdata;
                REG_DOUBLE_WINDOW: double_window_reg <= cfg_wdata;
                REG_PRESSED_LEVEL: pressed_level_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            last_edge_reg    <= '0;
            count_reg        <= 2'd0;
            ticking_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (take) begin
                phase_reg        <= phase_next;
                press_time_reg   <= press_time_next;
                release_time_reg <= release_time_next;
                last_edge_reg    <= last_edge_next;
                count_reg        <= count_next;
                ticking_reg      <= ticking_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg.press_event     <= event_next;
            m_data_reg.analysis_active <= ticking_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
